// File: hw/rtl/i2cms_pkg.sv
// shared types and constants for the i2c master bit sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package i2cms_pkg;

  localparam int BYTE_W     = 8;
  localparam int SAMP_W     = 9;
  localparam int MODE_W     = 3;
  localparam int CNT_W      = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_ADDR_ACK = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADDR_FIX = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WR_ACK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WR_FIX   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STOP     = 3'd5;

  localparam logic [CNT_W-1:0] CNT_START_LAST = 4'd1;
  localparam logic [CNT_W-1:0] CNT_BIT_LAST   = 4'd8;
  localparam logic [CNT_W-1:0] CNT_STOP_LAST  = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_BITS,
    ST_STOP
  } seq_state_t;

  // one bus phase as seen by the output stage
  typedef struct packed {
    logic busy;
    logic scl;
    logic sda;
    logic use_tx;
    logic last;
    logic is_read;
    logic samp_ack;
  } phase_t;

  // shift register control
  typedef struct packed {
    logic load;
    logic shift;
  } shift_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/i2c_master_bit_sequencer.sv
// channel  | valid/ready          | data                          | side
// in       | in_tvalid/in_tready  | in_tdata (byte, ack, samples) | in_tuser (mode)
// out      | out_tvalid/out_tready| out_tdata (scl, sda, rd, ack) | out_tlast (last phase)
// cfg      | cfg_we               | cfg_wdata (ninth bit level)   | -
// a command yields one phase per cycle while out_tready is high: start 20, write and
// read 18, stop 3; the next item is taken only once the sequencer is back in idle
// the phase count is set by the command state, the bit counter and the half-period flag
// synchronous active-low reset clears the sequencer and the output valid flag
// a phase left waiting in the output register by a low out_tready freezes the sequencer
// depends on i2cms_pkg, i2cms_ctrl, i2cms_shift
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_bit_sequencer (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [7:0] data_byte, [8] ack_flag, [17:9] line_samples
  input  wire [i2cms_pkg::IN_DATA_W-1:0]   in_tdata,
  // [2:0] mode
  input  wire [i2cms_pkg::MODE_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [0] scl_level, [1] sda_level, [9:2] read_byte, [10] ack_seen
  output logic [i2cms_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  input  wire                              cfg_we,
  input  wire                              cfg_wdata
);
  import i2cms_pkg::*;

  logic                ninth_r;
  logic                in_fire;
  logic                adv;
  phase_t              phase;
  shift_ctl_t          sctl;
  logic [SAMP_W-1:0]   tx_load;
  logic                ninth_bit;
  logic                tx_bit;
  logic                rx_bit;
  logic [BYTE_W-1:0]   rd_byte;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;
  logic                sda_now;

  assign in_tready = ~phase.busy;
  assign in_fire   = in_tvalid & in_tready;
  assign adv       = phase.busy & (~out_valid_r | out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ninth_r <= 1'b0;
    end else if (cfg_we) begin
      ninth_r <= cfg_wdata;
    end
  end

  always_comb begin
    case (in_tuser)
      MODE_ADDR_ACK, MODE_WR_ACK: ninth_bit = 1'b1;
      MODE_READ: ninth_bit = ~in_tdata[8];
      default: ninth_bit = ninth_r;
    endcase
    if (in_tuser == MODE_READ) begin
      tx_load = {{BYTE_W{1'b1}}, ninth_bit};
    end else begin
      tx_load = {in_tdata[7:0], ninth_bit};
    end
  end

  i2cms_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .mode  (in_tuser),
    .adv   (adv),
    .phase (phase),
    .sctl  (sctl)
  );

  i2cms_shift u_shift (
    .clk     (clk),
    .ctl     (sctl),
    .tx_load (tx_load),
    .rx_load (in_tdata[17:9]),
    .tx_bit  (tx_bit),
    .rx_bit  (rx_bit),
    .rd_byte (rd_byte)
  );

  // output register
  always_comb begin
    sda_now       = phase.use_tx ? tx_bit : phase.sda;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[0] = phase.scl;
      out_data_nxt[1] = sda_now;
      if (phase.last && phase.is_read) begin
        out_data_nxt[9:2] = rd_byte;
      end
      out_data_nxt[10] = phase.last & phase.samp_ack & rx_bit;
      out_last_nxt     = phase.last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[10:2] == '0))
    else $error("result fields set before last phase");

  a_stop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == MODE_STOP) |=> !in_tready)
    else $error("stop command did not start");

  a_last_scl_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tdata[0])
    else $error("last phase with scl low");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/i2cms_shift.sv
// bit-serial shift registers: outgoing sda bits, incoming samples, read byte
// depends on i2cms_pkg
`timescale 1ns / 1ps
`default_nettype none
module i2cms_shift (
  input  wire                          clk,
  input  wire i2cms_pkg::shift_ctl_t   ctl,
  input  wire [i2cms_pkg::SAMP_W-1:0]  tx_load,
  input  wire [i2cms_pkg::SAMP_W-1:0]  rx_load,
  output logic                         tx_bit,
  output logic                         rx_bit,
  output logic [i2cms_pkg::BYTE_W-1:0] rd_byte
);
  import i2cms_pkg::*;

  logic [SAMP_W-1:0] tx_r, tx_nxt;
  logic [SAMP_W-1:0] rx_r, rx_nxt;
  logic [BYTE_W-1:0] acc_r, acc_nxt;

  always_comb begin
    tx_nxt  = tx_r;
    rx_nxt  = rx_r;
    acc_nxt = acc_r;
    if (ctl.load) begin
      tx_nxt  = tx_load;
      rx_nxt  = rx_load;
      acc_nxt = '0;
    end else if (ctl.shift) begin
      tx_nxt  = {tx_r[SAMP_W-2:0], 1'b0};
      rx_nxt  = {rx_r[SAMP_W-2:0], 1'b0};
      acc_nxt = {acc_r[BYTE_W-2:0], rx_r[SAMP_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    tx_r  <= tx_nxt;
    rx_r  <= rx_nxt;
    acc_r <= acc_nxt;
  end

  assign tx_bit  = tx_r[SAMP_W-1];
  assign rx_bit  = rx_r[SAMP_W-1];
  assign rd_byte = acc_r;

endmodule
`default_nettype wire

// File: hw/rtl/i2cms_ctrl.sv
// phase sequencer: command state, bit counter and half-period flag
// depends on i2cms_pkg
`timescale 1ns / 1ps
`default_nettype none
module i2cms_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [i2cms_pkg::MODE_W-1:0]  mode,
  input  wire                          adv,
  output i2cms_pkg::phase_t            phase,
  output i2cms_pkg::shift_ctl_t        sctl
);
  import i2cms_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             half_r, half_nxt;
  logic             rd_r, rd_nxt;
  logic             sack_r, sack_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    half_nxt  = half_r;
    rd_nxt    = rd_r;
    sack_nxt  = sack_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt  = '0;
        half_nxt = 1'b0;
        if (start) begin
          rd_nxt   = (mode == MODE_READ);
          sack_nxt = (mode == MODE_ADDR_ACK) || (mode == MODE_WR_ACK);
          case (mode)
            MODE_ADDR_ACK, MODE_ADDR_FIX: state_nxt = ST_START;
            MODE_WR_ACK, MODE_WR_FIX, MODE_READ: state_nxt = ST_BITS;
            MODE_STOP: state_nxt = ST_STOP;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_START: begin
        if (adv) begin
          if (cnt_r == CNT_START_LAST) begin
            state_nxt = ST_BITS;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_BITS: begin
        if (adv) begin
          half_nxt = ~half_r;
          if (half_r) begin
            if (cnt_r == CNT_BIT_LAST) begin
              state_nxt = ST_IDLE;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      ST_STOP: begin
        if (adv) begin
          if (cnt_r == CNT_STOP_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      half_r  <= 1'b0;
      rd_r    <= 1'b0;
      sack_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      half_r  <= half_nxt;
      rd_r    <= rd_nxt;
      sack_r  <= sack_nxt;
    end
  end

  // outputs
  always_comb begin
    phase          = '0;
    phase.is_read  = rd_r;
    phase.samp_ack = sack_r;
    sctl.load      = 1'b0;
    sctl.shift     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        sctl.load = start;
      end
      ST_START: begin
        phase.busy = 1'b1;
        phase.scl  = 1'b1;
        phase.sda  = (cnt_r == '0);
      end
      ST_BITS: begin
        phase.busy   = 1'b1;
        phase.scl    = half_r;
        phase.use_tx = 1'b1;
        phase.last   = half_r && (cnt_r == CNT_BIT_LAST);
        sctl.shift   = adv && half_r;
      end
      ST_STOP: begin
        phase.busy = 1'b1;
        phase.scl  = (cnt_r != '0);
        phase.sda  = (cnt_r == CNT_STOP_LAST);
        phase.last = (cnt_r == CNT_STOP_LAST);
      end
      default: begin
        phase.busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire
